// File: rtl/kwlc_pkg.sv
// ----------------------------------------------------------------------------
// kwlc_pkg
// shared types, codes and the keyword table of the line classifier
// ----------------------------------------------------------------------------
`default_nettype none

package kwlc_pkg;

  // one transfer on the byte channel
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_t;

  // one transfer on the result channel
  typedef struct packed {
    logic [1:0]  line_class;
    logic [4:0]  keyword_number;
    logic [15:0] span_length;
  } out_t;

  // line tracking phase
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_BLANK = 2'd1,
    PH_WORD  = 2'd2,
    PH_REST  = 2'd3
  } phase_e;

  // line class / verdict codes
  localparam logic [1:0] CLASS_BLANK   = 2'd0;
  localparam logic [1:0] CLASS_KEYWORD = 2'd1;
  localparam logic [1:0] CLASS_EXPR    = 2'd2;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam logic [15:0] SPAN_MAX = 16'hFFFF;

  localparam int unsigned TABLE_SIZE = 32;

  // keyword text, right-justified, last character in the low byte
  localparam logic [71:0] KW_TEXT [TABLE_SIZE] = '{
    0:  72'("open"),
    1:  72'("close"),
    2:  72'("comment"),
    3:  72'("aside"),
    4:  72'("as"),
    5:  72'("literally"),
    6:  72'("decorator"),
    7:  72'("let"),
    8:  72'("increase"),
    9:  72'("decrease"),
    10: 72'("multiply"),
    11: 72'("divide"),
    12: 72'("enchant"),
    13: 72'("call"),
    14: 72'("if"),
    15: 72'("else"),
    16: 72'("for"),
    17: 72'("while"),
    default: 72'd0
  };

  // unused table slots have length zero and never match
  localparam logic [3:0] KW_LEN [TABLE_SIZE] = '{
    0: 4'd4, 1: 4'd5, 2: 4'd7, 3: 4'd5, 4: 4'd2, 5: 4'd9, 6: 4'd9, 7: 4'd3,
    8: 4'd8, 9: 4'd8, 10: 4'd8, 11: 4'd6, 12: 4'd7, 13: 4'd4, 14: 4'd2,
    15: 4'd4, 16: 4'd3, 17: 4'd5,
    default: 4'd0
  };

  // character at position pos of keyword k (only meaningful for pos < length)
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] pos);
    logic [3:0]  back;
    logic [6:0]  sh;
    logic [71:0] shifted;
    back    = KW_LEN[k] - 4'd1 - pos;
    sh      = {back, 3'b000};
    shifted = KW_TEXT[k] >> sh;
    return shifted[7:0];
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

`default_nettype wire

// File: rtl/kwlc_match.sv
// ----------------------------------------------------------------------------
// kwlc_match
// parallel keyword compare for one letter and end-of-word lookup
// ----------------------------------------------------------------------------
`default_nettype none

module kwlc_match #(
  parameter int unsigned KEYWORD_COUNT = 18,
  parameter int unsigned WLW           = 5
) (
  input  wire logic [KEYWORD_COUNT-1:0] alive_i,
  input  wire logic [WLW-1:0]           word_length_i,
  input  wire logic [7:0]               char_i,
  output logic      [KEYWORD_COUNT-1:0] alive_o,
  output logic                          hit_o,
  output logic      [4:0]               hit_index_o
);

  // per keyword: does the next letter continue the match
  always_comb begin
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      if ((word_length_i < WLW'(kwlc_pkg::KW_LEN[k])) &&
          (kwlc_pkg::kw_char(5'(k), word_length_i[3:0]) == char_i)) begin
        alive_o[k] = alive_i[k];
      end else begin
        alive_o[k] = 1'b0;
      end
    end
  end

  // lowest index still alive whose length equals the word length
  always_comb begin
    hit_o       = 1'b0;
    hit_index_o = '0;
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
      if (alive_i[k] && (word_length_i == WLW'(kwlc_pkg::KW_LEN[k]))) begin
        hit_o       = 1'b1;
        hit_index_o = 5'(k);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/kwlc_line.sv
// ----------------------------------------------------------------------------
// kwlc_line
// per-line state: phase, live keyword set, word and span counters
// ----------------------------------------------------------------------------
`default_nettype none

module kwlc_line #(
  parameter int unsigned MAX_WORD      = 31,
  parameter int unsigned KEYWORD_COUNT = 18
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire kwlc_pkg::in_t  data_i,
  output logic                emit_o,
  output kwlc_pkg::out_t      result_o
);

  localparam int unsigned WLW = $clog2(MAX_WORD + 1);

  kwlc_pkg::phase_e           phase_q, phase_d;
  logic [KEYWORD_COUNT-1:0]   alive_q, alive_d, alive_next;
  logic [WLW-1:0]             wlen_q, wlen_d;
  logic [15:0]                span_q, span_d, span_bump;
  logic [1:0]                 verdict_q, verdict_d;
  logic [4:0]                 index_q, index_d;
  logic                       hit;
  logic [4:0]                 hit_index;
  logic                       blank, letter, line_end;

  kwlc_match #(
    .KEYWORD_COUNT (KEYWORD_COUNT),
    .WLW           (WLW)
  ) u_match (
    .alive_i       (alive_q),
    .word_length_i (wlen_q),
    .char_i        (data_i.char_code),
    .alive_o       (alive_next),
    .hit_o         (hit),
    .hit_index_o   (hit_index)
  );

  assign blank     = (data_i.char_code == kwlc_pkg::CHAR_SPACE) ||
                     (data_i.char_code == kwlc_pkg::CHAR_TAB);
  assign line_end  = (data_i.char_code == kwlc_pkg::CHAR_LF) ||
                     (data_i.char_code == kwlc_pkg::CHAR_CR);
  assign letter    = kwlc_pkg::is_letter(data_i.char_code);
  assign span_bump = (span_q == kwlc_pkg::SPAN_MAX) ? span_q : span_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    alive_d   = alive_q;
    wlen_d    = wlen_q;
    span_d    = span_q;
    verdict_d = verdict_q;
    index_d   = index_q;
    emit_o    = 1'b0;

    if (data_i.end_of_input) begin
      emit_o = (phase_q != kwlc_pkg::PH_START);
    end else if (line_end) begin
      emit_o = 1'b1;
    end else begin
      case (phase_q)
        kwlc_pkg::PH_START, kwlc_pkg::PH_BLANK: begin
          if (blank) begin
            phase_d = kwlc_pkg::PH_BLANK;
          end else begin
            span_d = 16'd1;
            if (letter) begin
              phase_d = kwlc_pkg::PH_WORD;
              alive_d = alive_next;
              wlen_d  = wlen_q + WLW'(1);
            end else begin
              verdict_d = kwlc_pkg::CLASS_EXPR;
              phase_d   = kwlc_pkg::PH_REST;
            end
          end
        end
        kwlc_pkg::PH_WORD: begin
          span_d = span_bump;
          if (letter) begin
            if (wlen_q >= WLW'(MAX_WORD)) begin
              verdict_d = kwlc_pkg::CLASS_EXPR;
              phase_d   = kwlc_pkg::PH_REST;
            end else begin
              alive_d = alive_next;
              wlen_d  = wlen_q + WLW'(1);
            end
          end else if (blank) begin
            verdict_d = hit ? kwlc_pkg::CLASS_KEYWORD : kwlc_pkg::CLASS_EXPR;
            index_d   = hit ? hit_index : index_q;
            phase_d   = kwlc_pkg::PH_REST;
          end else begin
            verdict_d = kwlc_pkg::CLASS_EXPR;
            phase_d   = kwlc_pkg::PH_REST;
          end
        end
        default: begin
          span_d = span_bump;
        end
      endcase
    end

    // a line end, or an end of input that closes a line, clears everything for the next line
    if (emit_o) begin
      phase_d   = kwlc_pkg::PH_START;
      alive_d   = '1;
      wlen_d    = '0;
      span_d    = '0;
      verdict_d = kwlc_pkg::CLASS_BLANK;
      index_d   = '0;
    end
  end

  // result as seen at the line end, resolving an open word
  always_comb begin
    result_o = '0;
    case (phase_q)
      kwlc_pkg::PH_WORD: begin
        result_o.line_class     = hit ? kwlc_pkg::CLASS_KEYWORD : kwlc_pkg::CLASS_EXPR;
        result_o.keyword_number = hit ? hit_index : 5'd0;
        result_o.span_length    = span_q;
      end
      kwlc_pkg::PH_REST: begin
        result_o.line_class     = verdict_q;
        result_o.keyword_number = (verdict_q == kwlc_pkg::CLASS_KEYWORD) ? index_q : 5'd0;
        result_o.span_length    = span_q;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= kwlc_pkg::PH_START;
      alive_q   <= '1;
      wlen_q    <= '0;
      span_q    <= '0;
      verdict_q <= kwlc_pkg::CLASS_BLANK;
      index_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      alive_q   <= alive_d;
      wlen_q    <= wlen_d;
      span_q    <= span_d;
      verdict_q <= verdict_d;
      index_q   <= index_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/keyword_line_classifier.sv
// ----------------------------------------------------------------------------
// keyword_line_classifier
// byte stream line splitter and keyword-led line classifier
// ----------------------------------------------------------------------------
// usage:
//   in channel  : one byte (or an end-of-input mark) per transfer, valid/stall
//   out channel : one result per line end (LF, CR) or end of input that closes
//                 an open line; bytes inside a line give no result
//   path        : an input transfer goes through the input register, then the line
//                 state update into the result register, before its result is valid
//   throughput  : one byte per cycle while no line end waits on a stalled result; the
//                 per-line state takes each byte through the parallel keyword compare
//   stall       : a stalled result holds in the output register; bytes that do
//                 not end a line keep flowing past it, and the first line end
//                 waits in the input register until the result is taken
//   reset       : asynchronous, clears both registers' valid flags and puts
//                 the line state at line start with all keywords live
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_line_classifier #(
  parameter int unsigned MAX_WORD      = 31,
  parameter int unsigned KEYWORD_COUNT = 18
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire kwlc_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output kwlc_pkg::out_t      out_data_o
);

  // input register
  logic           s1_valid_q;
  kwlc_pkg::in_t  s1_data_q;
  logic           s1_fire;

  // line state outputs
  logic           emit;
  kwlc_pkg::out_t result;

  // output register
  logic           out_valid_q;
  kwlc_pkg::out_t out_data_q;
  logic           out_free;

  // output slot can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // a byte that ends a line needs a free output slot, others always go
  assign s1_fire    = s1_valid_q && (out_free || !emit);
  assign in_stall_o = s1_valid_q && !s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  kwlc_line #(
    .MAX_WORD      (MAX_WORD),
    .KEYWORD_COUNT (KEYWORD_COUNT)
  ) u_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_fire),
    .data_i   (s1_data_q),
    .emit_o   (emit),
    .result_o (result)
  );

  // result register, loaded only on a transfer that ends a line (line end or end of input)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_fire && emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
